// ===== hw/rtl/sas_pkg.sv =====
// Package for the snapshot array store: parameter defaults, operation and
// status codes, register reset value. No dependencies.
`default_nettype none

package sas_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int SNAP_SLOTS_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Operation codes on func
	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_SNAP = 2'd1;
	localparam logic [1:0] FUNC_GET  = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Reset value of the array length register
	localparam logic [4:0] LEN_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== hw/rtl/snapshot_array_store.sv =====
// Top level of the snapshot array store: control sequencer and two RAMs.
// Depends on sas_pkg and sas_ram.
//
// Usage:
//   Requests enter on start/func/index/value/snap_id and are taken at a
//   rising edge with start high and busy low. Each request gives exactly
//   one result on read_value/new_snap_id/status, marked by done for one
//   cycle; the receiver cannot stall, so results are never held.
//   Request handling:
//     set, flagged requests, func 3 and get of an untaken snapshot: result
//       in the next cycle, busy stays low (one request a cycle).
//     get of a taken snapshot: busy during the snapshot RAM read; the data
//       goes through the RAM's read register, then the result registers.
//     snap: busy while the copy runs, one current-array RAM read and one
//       snapshot RAM write per entry, result right after the last write.
//   The length register is written on cfg_valid/cfg_ready/cfg_data; the user
//   must write it only while idle, which the block does not enforce.
//   cfg_ready is always high. Reset: snapshot count goes to zero and the
//   length to 16, then a clearing pass zeroes the current array, busy high.
`default_nettype none

module snapshot_array_store #(
	parameter int ENTRIES    = sas_pkg::ENTRIES_DEF,
	parameter int SNAP_SLOTS = sas_pkg::SNAP_SLOTS_DEF,
	parameter int DATA_WIDTH = sas_pkg::DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         func,
	input  wire logic [3:0]         index,
	input  wire logic signed [31:0] value,
	input  wire logic [3:0]         snap_id,
	output logic                    done,
	output logic signed [31:0]      read_value,
	output logic [3:0]              new_snap_id,
	output logic [1:0]              status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [4:0]         cfg_data
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SDEPTH  = SNAP_SLOTS * ENTRIES;
	localparam int SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int CNT_W   = $clog2(SNAP_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_COPY  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_GET   = 3'd4;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [SADDR_W-1:0] waddr_q;
	logic [CNT_W-1:0]   count_q;
	logic [4:0]         len_q;
	logic               copy_s1;
	logic               done_q;
	logic [31:0]        read_value_q;
	logic [3:0]         new_snap_id_q;
	logic [1:0]         status_q;

	logic               accept;
	logic               in_range;
	logic               taken;
	logic               full;
	logic [63:0]        value_ext;
	logic [31:0]        index_ext;
	logic [31:0]        get_addr_full;
	logic [63:0]        snap_rd_ext;

	logic               cur_we;
	logic [IDX_W-1:0]   cur_waddr;
	logic [DATA_WIDTH-1:0] cur_wdata;
	logic               cur_re;
	logic [DATA_WIDTH-1:0] cur_rdata;
	logic               snap_re;
	logic [DATA_WIDTH-1:0] snap_rdata;

	// Decode the request against length and snapshot count
	assign accept        = start && !busy;
	assign index_ext     = 32'(index);
	assign in_range      = ({1'b0, index} < len_q) && (index_ext < 32'(ENTRIES));
	assign taken         = (32'(snap_id) < 32'(count_q)) && (32'(snap_id) < 32'(SNAP_SLOTS));
	assign full          = 32'(count_q) >= 32'(SNAP_SLOTS);
	assign value_ext     = {{32{value[31]}}, value};
	assign get_addr_full = 32'(snap_id) * 32'(ENTRIES) + index_ext;
	assign snap_rd_ext   = 64'(snap_rdata);

	// Current array port: clear pass, set write, copy read
	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = index_ext[IDX_W-1:0];
		cur_wdata = value_ext[DATA_WIDTH-1:0];
		if (state_q == ST_CLEAR) begin
			cur_we    = 1'b1;
			cur_waddr = cnt_q;
			cur_wdata = '0;
		end else if (accept && func == sas_pkg::FUNC_SET && in_range) begin
			cur_we = 1'b1;
		end
	end

	assign cur_re  = (state_q == ST_COPY);
	assign snap_re = accept && func == sas_pkg::FUNC_GET && in_range && taken;

	sas_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(ENTRIES)
	) u_cur_ram (
		.clk  (clk),
		.we   (cur_we),
		.waddr(cur_waddr),
		.wdata(cur_wdata),
		.re   (cur_re),
		.raddr(cnt_q),
		.rdata(cur_rdata)
	);

	sas_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(SDEPTH)
	) u_snap_ram (
		.clk  (clk),
		.we   (copy_s1),
		.waddr(waddr_q),
		.wdata(cur_rdata),
		.re   (snap_re),
		.raddr(get_addr_full[SADDR_W-1:0]),
		.rdata(snap_rdata)
	);

	// Sequence requests, copy snapshots, count slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			waddr_q <= '0;
			count_q <= '0;
			copy_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			copy_s1 <= (state_q == ST_COPY);
			if (copy_s1) begin
				waddr_q <= waddr_q + SADDR_W'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (func == sas_pkg::FUNC_SNAP && !full) begin
							cnt_q   <= '0;
							state_q <= ST_COPY;
						end else if (snap_re) begin
							state_q <= ST_GET;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_COPY: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					count_q <= count_q + CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_GET: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			read_value_q  <= '0;
			new_snap_id_q <= '0;
			status_q      <= sas_pkg::STATUS_OK;
			if ((func == sas_pkg::FUNC_SET || func == sas_pkg::FUNC_GET) && !in_range) begin
				status_q <= sas_pkg::STATUS_RANGE;
			end else if (func == sas_pkg::FUNC_SNAP && full) begin
				status_q <= sas_pkg::STATUS_FULL;
			end
		end else if (state_q == ST_DRAIN) begin
			new_snap_id_q <= 4'(count_q);
		end else if (state_q == ST_GET) begin
			read_value_q <= snap_rd_ext[31:0];
		end
	end

	// Hold the array length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= sas_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign read_value  = read_value_q;
	assign new_snap_id = new_snap_id_q;
	assign status      = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sas_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module sas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== verif/snapshot_array_store_test.sv =====
// Self-checking testbench for the snapshot array store: directed and random
// set/snap/get requests checked against a built-in versioned-array predictor.
// Depends on sas_pkg and the snapshot_array_store RTL.
`timescale 1ns / 100ps

module snapshot_array_store_test;

	localparam logic [1:0] FUNC_NONE   = 2'd3;
	localparam int         WORDS       = sas_pkg::ENTRIES_DEF;
	localparam int         SLOTS       = sas_pkg::SNAP_SLOTS_DEF;
	localparam int         STALL_LIMIT = 2000;
	localparam int         REPORT_MAX  = 10;
	localparam int         DUE_DEPTH   = 16;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [31:0] word;
		logic [3:0]  sid;
	} request_t;

	typedef struct packed {
		logic [31:0] rd;
		logic [3:0]  nid;
		logic [1:0]  code;
	} reply_t;

	typedef struct packed {
		request_t req;
		reply_t   rep;
	} due_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         func = sas_pkg::FUNC_SET;
	logic [3:0]         index = '0;
	logic signed [31:0] value = '0;
	logic [3:0]         snap_id = '0;
	logic               done;
	logic signed [31:0] read_value;
	logic [3:0]         new_snap_id;
	logic [1:0]         status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = '0;

	// Predictor state: live array, stored snapshots, length register copy
	logic [31:0] live_words [WORDS];
	logic [31:0] saved_words [SLOTS][WORDS];
	int          snaps_taken;
	logic [4:0]  length_reg;

	// Outstanding replies, oldest first, in a ring
	due_t due_ring [DUE_DEPTH];
	int   due_wr;
	int   due_rd;
	int   idle_pct;
	int   mismatches;
	int   replies_checked;
	int   length_writes;
	int   ops_by_func [4];
	int   stall_cycles;

	snapshot_array_store DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.index       (index),
		.value       (value),
		.snap_id     (snap_id),
		.done        (done),
		.read_value  (read_value),
		.new_snap_id (new_snap_id),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int live_length();
		return (length_reg > WORDS) ? WORDS : int'(length_reg);
	endfunction

	function automatic logic [3:0] rand4();
		return 4'($urandom);
	endfunction

	function automatic int due_count();
		return due_wr - due_rd;
	endfunction

	// Append one expected reply behind the outstanding ones
	function automatic void enqueue_due(due_t d);
		due_ring[due_wr % DUE_DEPTH] = d;
		due_wr++;
	endfunction

	// Apply one request to the versioned array and return its reply
	function automatic reply_t versioned_array_reply(request_t r);
		reply_t o;
		o = '0;
		case (r.op)
			sas_pkg::FUNC_SET: begin
				if (r.idx >= live_length())
					o.code = sas_pkg::STATUS_RANGE;
				else
					live_words[r.idx] = r.word;
			end
			sas_pkg::FUNC_SNAP: begin
				if (snaps_taken >= SLOTS) begin
					o.code = sas_pkg::STATUS_FULL;
				end else begin
					saved_words[snaps_taken] = live_words;
					o.nid = snaps_taken[3:0];
					snaps_taken++;
				end
			end
			sas_pkg::FUNC_GET: begin
				if (r.idx >= live_length())
					o.code = sas_pkg::STATUS_RANGE;
				else if (r.sid < snaps_taken)
					o.rd = saved_words[r.sid][r.idx];
			end
			default: ;
		endcase
		return o;
	endfunction

	// Send one request, with random idle cycles ahead of it
	task automatic issue_request(input logic [1:0] op, input logic [3:0] idx,
			input logic [31:0] word, input logic [3:0] sid);
		request_t r;
		due_t     d;
		r = '{op, idx, word, sid};
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		func    <= op;
		index   <= idx;
		value   <= word;
		snap_id <= sid;
		do @(posedge clk); while (busy);
		d.req = r;
		d.rep = versioned_array_reply(r);
		enqueue_due(d);
		ops_by_func[op]++;
	endtask

	// Drop start and wait until every reply is in and the block is idle
	task automatic drain_replies();
		start <= 1'b0;
		while (due_count() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
	endtask

	task automatic write_length(input logic [4:0] len);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		length_reg = len;
		length_writes++;
	endtask

	// Random request: mostly in-range sets and gets of taken snapshots
	task automatic random_request();
		int          pick;
		logic [3:0]  idx;
		logic [3:0]  sid;
		logic [31:0] word;
		logic [1:0]  op;
		pick = $urandom_range(99);
		if (pick < 50)
			op = sas_pkg::FUNC_SET;
		else if (pick < 52)
			op = sas_pkg::FUNC_SNAP;
		else if (pick < 95)
			op = sas_pkg::FUNC_GET;
		else
			op = FUNC_NONE;
		if (live_length() > 0 && $urandom_range(9) < 8)
			idx = 4'($urandom_range(live_length() - 1));
		else
			idx = rand4();
		if (snaps_taken > 0 && $urandom_range(9) < 8)
			sid = 4'($urandom_range(snaps_taken - 1));
		else
			sid = rand4();
		case ($urandom_range(15))
			0: word = 32'h8000_0000;
			1: word = 32'h7FFF_FFFF;
			2: word = 32'hFFFF_FFFF;
			3: word = 32'h0000_0000;
			default: word = $urandom;
		endcase
		issue_request(op, idx, word, sid);
	endtask

	task automatic report_bad(input string what, input due_t want, input reply_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%s: op %0d idx %0d sid %0d", what, want.req.op, want.req.idx,
				want.req.sid);
			$display("  want rd %0d nid %0d st %0d | got rd %0d nid %0d st %0d",
				$signed(want.rep.rd), want.rep.nid, want.rep.code,
				$signed(got.rd), got.nid, got.code);
		end
	endtask

	// Check each reply against the oldest outstanding request
	always @(posedge clk) begin : check_reply
		due_t   head;
		reply_t got;
		if (arst_n && done) begin
			got = '{read_value, new_snap_id, status};
			replies_checked++;
			if (due_count() == 0) begin
				report_bad("reply with no request outstanding", '0, got);
			end else begin
				head = due_ring[due_rd % DUE_DEPTH];
				due_rd++;
				if (got.rd !== head.rep.rd || got.nid !== head.rep.nid
						|| got.code !== head.rep.code)
					report_bad("reply mismatch", head, got);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no request, reply or register write for %0d cycles",
				STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Gets before any snapshot answer zero
	task automatic test_reset_state();
		issue_request(sas_pkg::FUNC_GET, 4'd0, $urandom, 4'd0);
		issue_request(sas_pkg::FUNC_GET, 4'd15, $urandom, 4'd15);
	endtask

	// Extreme values through set, snap and get; later sets leave the snapshot alone
	task automatic test_set_snap_get();
		issue_request(sas_pkg::FUNC_SET, 4'd0, 32'h7FFF_FFFF, rand4());
		issue_request(sas_pkg::FUNC_SET, 4'd15, 32'h8000_0000, rand4());
		issue_request(sas_pkg::FUNC_SET, 4'd6, 32'hFFFF_FFFF, rand4());
		issue_request(sas_pkg::FUNC_SNAP, rand4(), $urandom, rand4());
		issue_request(sas_pkg::FUNC_SET, 4'd0, 32'h0000_0000, rand4());
		issue_request(sas_pkg::FUNC_GET, 4'd0, $urandom, 4'd0);
		issue_request(sas_pkg::FUNC_GET, 4'd15, $urandom, 4'd0);
		issue_request(sas_pkg::FUNC_GET, 4'd6, $urandom, 4'd0);
		issue_request(sas_pkg::FUNC_GET, 4'd3, $urandom, 4'd0);
		issue_request(sas_pkg::FUNC_GET, 4'd0, $urandom, 4'd1);
	endtask

	// Unused operation code does nothing
	task automatic test_unused_code();
		issue_request(FUNC_NONE, 4'hF, 32'hFFFF_FFFF, 4'hF);
		issue_request(FUNC_NONE, rand4(), $urandom, rand4());
	endtask

	// Zero length, length above capacity, length one, then back to full
	task automatic test_length_limits();
		write_length(5'd0);
		issue_request(sas_pkg::FUNC_SET, 4'd0, $urandom, rand4());
		issue_request(sas_pkg::FUNC_GET, 4'd0, $urandom, 4'd0);
		write_length(5'd31);
		issue_request(sas_pkg::FUNC_SET, 4'd15, 32'h1234_5678, rand4());
		issue_request(sas_pkg::FUNC_GET, 4'd15, $urandom, 4'd0);
		write_length(5'd1);
		issue_request(sas_pkg::FUNC_SET, 4'd1, $urandom, rand4());
		issue_request(sas_pkg::FUNC_SET, 4'd0, $urandom, rand4());
		issue_request(sas_pkg::FUNC_GET, 4'd15, $urandom, 4'd0);
		write_length(5'd16);
		issue_request(sas_pkg::FUNC_SNAP, rand4(), $urandom, rand4());
		issue_request(sas_pkg::FUNC_GET, 4'd15, $urandom, 4'd1);
	endtask

	task automatic test_random_mix(input int count, input int idle, input logic [4:0] len);
		write_length(len);
		idle_pct = idle;
		repeat (count)
			random_request();
	endtask

	// Fill every snapshot slot, then snap into a full store
	task automatic test_store_full();
		write_length(5'd16);
		idle_pct = 13;
		while (snaps_taken < SLOTS)
			issue_request(sas_pkg::FUNC_SNAP, rand4(), $urandom, rand4());
		repeat (2)
			issue_request(sas_pkg::FUNC_SNAP, rand4(), $urandom, rand4());
		issue_request(sas_pkg::FUNC_GET, rand4(), $urandom, 4'd15);
		issue_request(sas_pkg::FUNC_GET, 4'd0, $urandom, 4'd0);
	endtask

	initial begin
		for (int i = 0; i < WORDS; i++)
			live_words[i] = '0;
		snaps_taken     = 0;
		length_reg      = sas_pkg::LEN_RESET;
		due_wr          = 0;
		due_rd          = 0;
		idle_pct        = 13;
		mismatches      = 0;
		replies_checked = 0;
		length_writes   = 0;
		stall_cycles    = 0;
		ops_by_func     = '{default: 0};

		// Hold reset, then wait out the clearing pass
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);

		test_reset_state();
		test_set_snap_get();
		test_unused_code();
		test_length_limits();
		test_random_mix(210, 13, 5'd16);
		test_random_mix(210, 66, 5'($urandom_range(1, 15)));
		test_random_mix(210, 0, 5'($urandom_range(1, 31)));
		test_store_full();

		drain_replies();
		repeat (20) @(posedge clk);
		mismatches += due_count();

		$display("Covered %0d sets, %0d snaps, %0d gets, %0d no-ops; %0d replies checked",
			ops_by_func[sas_pkg::FUNC_SET], ops_by_func[sas_pkg::FUNC_SNAP],
			ops_by_func[sas_pkg::FUNC_GET], ops_by_func[FUNC_NONE], replies_checked);
		$display("Length register written %0d times, %0d snapshots taken, %0d mismatches",
			length_writes, snaps_taken, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
